[design/miss_buffer_with_load_fill_queue_assert.svh]
// assertion helpers for the miss buffer top module
`ifndef MISS_BUFFER_WITH_LOAD_FILL_QUEUE_ASSERT_SVH
`define MISS_BUFFER_WITH_LOAD_FILL_QUEUE_ASSERT_SVH

// condition holds at every edge out of reset
`define MBQ_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MBQ_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[design/mbq_pkg.sv]
`timescale 1ns / 1ps
package mbq_pkg;

   localparam int LOAD_SLOTS       = 16;
   localparam int MISS_ENTRIES     = 8;
   localparam int WAKEUPS_PER_TICK = 2;
   localparam int LINE_BYTES       = 64;

   localparam int ADDR_W  = 48;
   localparam int SLOT_W  = $clog2(LOAD_SLOTS);
   localparam int ENT_W   = (MISS_ENTRIES > 1) ? $clog2(MISS_ENTRIES) : 1;
   localparam int OFF_W   = $clog2(LINE_BYTES);
   localparam int LINE_W  = ADDR_W - OFF_W;
   localparam int WAKE_W  = $clog2(WAKEUPS_PER_TICK + 1);
   localparam int CNT_W   = 10;
   localparam int L2LAT_W = 8;

   // commands
   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_LOAD_MISS = 3'd1;
   localparam logic [2:0] CMD_LINE_MISS = 3'd2;
   localparam logic [2:0] CMD_ANNUL     = 3'd3;
   localparam logic [2:0] CMD_FLUSH     = 3'd4;
   localparam logic [2:0] CMD_RESTART   = 3'd5;

   // result kinds
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_WAKE   = 2'd1;
   localparam logic [1:0] KIND_TO_L2  = 2'd2;
   localparam logic [1:0] KIND_TO_L1  = 2'd3;

   // load slot states
   localparam logic [1:0] SLOT_FREE  = 2'd0;
   localparam logic [1:0] SLOT_WAIT  = 2'd1;
   localparam logic [1:0] SLOT_READY = 2'd2;

   // line entry phases
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_TO_L2 = 2'd1;
   localparam logic [1:0] PH_TO_L1 = 2'd2;

   // csr indexes
   localparam logic CSR_MEM_LAT = 1'b0;
   localparam logic CSR_L2_LAT  = 1'b1;

   localparam logic [CNT_W-1:0]   MEM_LAT_RESET = 10'd112;
   localparam logic [L2LAT_W-1:0] L2_LAT_RESET  = 8'd16;

   typedef struct packed {
      logic [1:0]        kind;
      logic              ok;
      logic [3:0]        slot;
      logic [ADDR_W-1:0] address;
      logic [15:0]       rob_tag;
      logic [7:0]        thread;
      logic              fill_data;
      logic              fill_instr;
   } result_type;

   typedef struct packed {
      logic                    alloc;
      logic [LINE_W-1:0]       line;
      logic                    hit;
      logic                    icache;
      logic [15:0]             rob;
      logic [7:0]              thread;
      logic                    flush;
      logic [MISS_ENTRIES-1:0] keep;
      logic                    scan;
      logic [ENT_W-1:0]        scan_idx;
      logic [CNT_W-1:0]        mem_lat;
      logic [L2LAT_W-1:0]      l2_lat;
   } lines_ctl_type;

   typedef struct packed {
      logic              alloc_ok;
      logic [ENT_W-1:0]  alloc_idx;
      logic              scan_l2;
      logic              scan_l1;
      logic [LINE_W-1:0] line;
      logic [15:0]       rob;
      logic [7:0]        thread;
      logic              dcache;
      logic              icache;
   } lines_sts_type;

endpackage

[design/mbq_lines.sv]
`timescale 1ns / 1ps
module mbq_lines (
   input  logic                  clock,
   input  logic                  reset,
   input  mbq_pkg::lines_ctl_type ctl,
   output mbq_pkg::lines_sts_type sts
);

   logic [mbq_pkg::MISS_ENTRIES-1:0] valid_ff;
   logic [1:0]                 phase_ff [mbq_pkg::MISS_ENTRIES];
   logic [mbq_pkg::CNT_W-1:0]  cnt_ff   [mbq_pkg::MISS_ENTRIES];
   logic [mbq_pkg::LINE_W-1:0] line_ff  [mbq_pkg::MISS_ENTRIES];
   logic [15:0]                rob_ff   [mbq_pkg::MISS_ENTRIES];
   logic [7:0]                 thr_ff   [mbq_pkg::MISS_ENTRIES];
   logic [mbq_pkg::MISS_ENTRIES-1:0] ic_ff;
   logic [mbq_pkg::MISS_ENTRIES-1:0] dc_ff;

   logic [mbq_pkg::MISS_ENTRIES-1:0] match;
   logic                       hit_found;
   logic                       free_found;
   logic [mbq_pkg::ENT_W-1:0]  hit_idx;
   logic [mbq_pkg::ENT_W-1:0]  free_idx;
   logic [mbq_pkg::ENT_W-1:0]  new_idx;
   logic [1:0]                 cur_phase;
   logic [mbq_pkg::CNT_W-1:0]  cnt_dec;
   logic                       live;
   logic                       zero;

   // parallel tag match, first match else first free entry
   always_comb begin
      hit_found  = 1'b0;
      free_found = 1'b0;
      hit_idx    = '0;
      free_idx   = '0;
      for (int i = mbq_pkg::MISS_ENTRIES - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (line_ff[i] == ctl.line);
         if (match[i]) begin
            hit_found = 1'b1;
            hit_idx   = mbq_pkg::ENT_W'(i);
         end
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = mbq_pkg::ENT_W'(i);
         end
      end
   end

   assign new_idx = hit_found ? hit_idx : free_idx;

   // shared countdown unit, one entry per cycle while ctl.scan is high
   assign cur_phase = phase_ff[ctl.scan_idx];
   assign cnt_dec   = cnt_ff[ctl.scan_idx] - mbq_pkg::CNT_W'(1);
   assign zero      = (cnt_dec == '0);
   assign live      = valid_ff[ctl.scan_idx] && (cur_phase != mbq_pkg::PH_IDLE);

   always_comb begin
      sts.alloc_ok  = hit_found || free_found;
      sts.alloc_idx = new_idx;
      sts.scan_l2   = ctl.scan && live && zero && (cur_phase == mbq_pkg::PH_TO_L2);
      sts.scan_l1   = ctl.scan && live && zero && (cur_phase == mbq_pkg::PH_TO_L1);
      sts.line      = line_ff[ctl.scan_idx];
      sts.rob       = rob_ff[ctl.scan_idx];
      sts.thread    = thr_ff[ctl.scan_idx];
      sts.dcache    = dc_ff[ctl.scan_idx];
      sts.icache    = ic_ff[ctl.scan_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < mbq_pkg::MISS_ENTRIES; i++) begin
            phase_ff[i] <= mbq_pkg::PH_IDLE;
            cnt_ff[i]   <= '0;
         end
      end else begin
         if (ctl.alloc && !hit_found && free_found) begin
            valid_ff[new_idx] <= 1'b1;
            if (ctl.hit) begin
               phase_ff[new_idx] <= mbq_pkg::PH_TO_L1;
               cnt_ff[new_idx]   <= mbq_pkg::CNT_W'(ctl.l2_lat);
            end else begin
               phase_ff[new_idx] <= mbq_pkg::PH_TO_L2;
               cnt_ff[new_idx]   <= ctl.mem_lat;
            end
         end
         if (ctl.flush) begin
            for (int j = 0; j < mbq_pkg::MISS_ENTRIES; j++) begin
               if (valid_ff[j] && !ctl.keep[j] && (thr_ff[j] == ctl.thread)) begin
                  valid_ff[j] <= 1'b0;
                  phase_ff[j] <= mbq_pkg::PH_IDLE;
                  cnt_ff[j]   <= '0;
               end
            end
         end
         if (ctl.scan && live) begin
            cnt_ff[ctl.scan_idx] <= cnt_dec;
            if (zero) begin
               if (cur_phase == mbq_pkg::PH_TO_L2) begin
                  phase_ff[ctl.scan_idx] <= mbq_pkg::PH_TO_L1;
                  cnt_ff[ctl.scan_idx]   <= mbq_pkg::CNT_W'(ctl.l2_lat);
               end else begin
                  valid_ff[ctl.scan_idx] <= 1'b0;
                  phase_ff[ctl.scan_idx] <= mbq_pkg::PH_IDLE;
                  cnt_ff[ctl.scan_idx]   <= '0;
               end
            end
         end
      end
   end

   // owner and tag fields
   always_ff @(posedge clock) begin
      if (ctl.alloc && sts.alloc_ok) begin
         if (hit_found) begin
            if (ctl.icache) begin
               ic_ff[new_idx] <= 1'b1;
            end else begin
               dc_ff[new_idx] <= 1'b1;
            end
         end else begin
            line_ff[new_idx] <= ctl.line;
            rob_ff[new_idx]  <= ctl.rob;
            thr_ff[new_idx]  <= ctl.thread;
            ic_ff[new_idx]   <= ctl.icache;
            dc_ff[new_idx]   <= !ctl.icache;
         end
      end
   end

endmodule

[design/miss_buffer_with_load_fill_queue.sv]
`timescale 1ns / 1ps
// miss status tracker: line entries with merge and countdown, plus a load fill queue
// req channel: one command beat (tick, load miss, line miss, annul, flush, restart);
//    req_stall is high while a command is being worked on
// rsp channel: every command yields a status beat; a tick then adds up to
//    WAKEUPS_PER_TICK load wakeups (lowest slot first) and L2/L1 delivery beats in
//    entry order; rsp_last marks the final beat of the command
// csr channel: memory_latency (index 0) and l2_latency (index 1), always ready;
//    write only while the block is idle
// sequence: a non-tick command passes the execute and done states, its status beat
//    goes out, and the next command is taken after it; a tick walks the ready slots one per
//    cycle and then the line entries one per cycle through a single shared countdown
//    unit, each walk holding while rsp_stall keeps the output register full
// each beat is held until the next beat or the end of the command, so the last flag is known before it goes out
// rsp_stall: the sequencer freezes until the output register drains
// reset: all load slots free, no line entries, latencies back to 112 and 16
module miss_buffer_with_load_fill_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [47:0] req_address,
   input  logic        req_hit_in_l2,
   input  logic        req_is_icache,
   input  logic [15:0] req_rob_tag,
   input  logic [7:0]  req_thread_id,
   input  logic [3:0]  req_load_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic        rsp_ok,
   output logic [3:0]  rsp_slot,
   output logic [47:0] rsp_out_address,
   output logic [15:0] rsp_out_rob_tag,
   output logic [7:0]  rsp_out_thread,
   output logic        rsp_fill_data,
   output logic        rsp_fill_instr,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [9:0]  csr_data
);

`include "miss_buffer_with_load_fill_queue_assert.svh"

   localparam int LS = mbq_pkg::LOAD_SLOTS;
   localparam int ME = mbq_pkg::MISS_ENTRIES;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_WAKE = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // latched command beat
   logic [2:0]  cmd_ff;
   logic [47:0] addr_ff;
   logic        hit_ff;
   logic        ic_ff;
   logic [15:0] rob_ff;
   logic [7:0]  thr_ff;
   logic [3:0]  lslot_ff;

   logic [mbq_pkg::CNT_W-1:0]   mem_lat_ff;
   logic [mbq_pkg::L2LAT_W-1:0] l2_lat_ff;

   // load slot table
   logic [1:0]                slot_state_ff [LS];
   logic [LS-1:0]             linked_ff;
   logic [mbq_pkg::ENT_W-1:0] slot_entry_ff [LS];
   logic [47:0]               slot_addr_ff  [LS];
   logic [15:0]               slot_rob_ff   [LS];
   logic [7:0]                slot_thr_ff   [LS];

   // result staging
   mbq_pkg::result_type hold_ff;
   logic                hold_valid_ff;
   mbq_pkg::result_type rsp_ff;
   logic                rsp_valid_ff;
   logic                rsp_last_ff;

   logic [mbq_pkg::WAKE_W-1:0] wake_cnt_ff;
   logic [mbq_pkg::ENT_W-1:0]  scan_idx_ff;

   logic                      accept;
   logic                      out_free;
   logic                      step;
   logic [LS-1:0]             busy_vec;
   logic [LS-1:0]             gone_vec;
   logic [LS-1:0]             l1_vec;
   logic                      slot_found;
   logic [mbq_pkg::SLOT_W-1:0] free_idx;
   logic                      ready_any;
   logic [mbq_pkg::SLOT_W-1:0] ready_idx;
   logic                      wake_go;
   logic                      load_ok;
   logic [ME-1:0]             keep;
   logic                      new_valid;
   mbq_pkg::result_type       new_res;
   logic                      push;
   logic                      in_exec;

   mbq_pkg::lines_ctl_type lines_ctl;
   mbq_pkg::lines_sts_type lines_sts;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = out_free && (state_ff != ST_IDLE);
   assign in_exec   = step && (state_ff == ST_EXEC);

   // per-slot status, lowest free and lowest ready slot
   always_comb begin
      slot_found = 1'b0;
      free_idx   = '0;
      ready_any  = 1'b0;
      ready_idx  = '0;
      for (int s = LS - 1; s >= 0; s--) begin
         busy_vec[s] = (slot_state_ff[s] != mbq_pkg::SLOT_FREE);
         gone_vec[s] = busy_vec[s] && (slot_thr_ff[s] == thr_ff);
         l1_vec[s]   = lines_sts.scan_l1 && linked_ff[s] && (slot_entry_ff[s] == scan_idx_ff);
         if (!busy_vec[s]) begin
            slot_found = 1'b1;
            free_idx   = mbq_pkg::SLOT_W'(s);
         end
         if (slot_state_ff[s] == mbq_pkg::SLOT_READY) begin
            ready_any = 1'b1;
            ready_idx = mbq_pkg::SLOT_W'(s);
         end
      end
   end

   // entries that still have waiters once a flush has dropped its slots
   always_comb begin
      for (int j = 0; j < ME; j++) begin
         keep[j] = 1'b0;
         for (int s = 0; s < LS; s++) begin
            if (linked_ff[s] && !gone_vec[s] && (slot_entry_ff[s] == mbq_pkg::ENT_W'(j))) begin
               keep[j] = 1'b1;
            end
         end
      end
   end

   assign load_ok = slot_found && lines_sts.alloc_ok;
   assign wake_go = ready_any && (wake_cnt_ff < mbq_pkg::WAKE_W'(mbq_pkg::WAKEUPS_PER_TICK));

   always_comb begin
      lines_ctl.alloc    = in_exec && ((cmd_ff == mbq_pkg::CMD_LINE_MISS) ||
                                       ((cmd_ff == mbq_pkg::CMD_LOAD_MISS) && slot_found));
      lines_ctl.line     = addr_ff[47:mbq_pkg::OFF_W];
      lines_ctl.hit      = hit_ff;
      lines_ctl.icache   = (cmd_ff == mbq_pkg::CMD_LINE_MISS) && ic_ff;
      lines_ctl.rob      = rob_ff;
      lines_ctl.thread   = thr_ff;
      lines_ctl.flush    = in_exec && (cmd_ff == mbq_pkg::CMD_FLUSH);
      lines_ctl.keep     = keep;
      lines_ctl.scan     = step && (state_ff == ST_SCAN);
      lines_ctl.scan_idx = scan_idx_ff;
      lines_ctl.mem_lat  = mem_lat_ff;
      lines_ctl.l2_lat   = l2_lat_ff;
   end

   mbq_lines u_lines (
      .clock (clock),
      .reset (reset),
      .ctl   (lines_ctl),
      .sts   (lines_sts)
   );

   // result produced by the current step
   always_comb begin
      new_valid = 1'b0;
      new_res   = '0;
      case (state_ff)
         ST_EXEC: begin
            new_valid    = 1'b1;
            new_res.kind = mbq_pkg::KIND_STATUS;
            new_res.ok   = 1'b1;
            case (cmd_ff)
               mbq_pkg::CMD_LOAD_MISS: begin
                  new_res.ok   = load_ok;
                  new_res.slot = load_ok ? 4'(free_idx) : 4'd0;
               end
               mbq_pkg::CMD_LINE_MISS: begin
                  new_res.ok   = lines_sts.alloc_ok;
                  new_res.slot = lines_sts.alloc_ok ? 4'(lines_sts.alloc_idx) : 4'd0;
               end
               default: begin
                  new_res.ok = 1'b1;
               end
            endcase
         end
         ST_WAKE: begin
            if (wake_go) begin
               new_valid       = 1'b1;
               new_res.kind    = mbq_pkg::KIND_WAKE;
               new_res.ok      = 1'b1;
               new_res.slot    = 4'(ready_idx);
               new_res.address = slot_addr_ff[ready_idx];
               new_res.rob_tag = slot_rob_ff[ready_idx];
               new_res.thread  = slot_thr_ff[ready_idx];
            end
         end
         ST_SCAN: begin
            if (lines_sts.scan_l2 || lines_sts.scan_l1) begin
               new_valid          = 1'b1;
               new_res.kind       = lines_sts.scan_l1 ? mbq_pkg::KIND_TO_L1 : mbq_pkg::KIND_TO_L2;
               new_res.ok         = 1'b1;
               new_res.slot       = 4'(scan_idx_ff);
               new_res.address    = {lines_sts.line, {mbq_pkg::OFF_W{1'b0}}};
               new_res.rob_tag    = lines_sts.rob;
               new_res.thread     = lines_sts.thread;
               new_res.fill_data  = lines_sts.scan_l1 && lines_sts.dcache;
               new_res.fill_instr = lines_sts.scan_l1 && lines_sts.icache;
            end
         end
         default: begin
            new_valid = 1'b0;
         end
      endcase
   end

   // held beat leaves when a newer one arrives or the command ends
   assign push = step && hold_valid_ff && (new_valid || (state_ff == ST_DONE));

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (step) begin
               state_in = (cmd_ff == mbq_pkg::CMD_TICK) ? ST_WAKE : ST_DONE;
            end
         end
         ST_WAKE: begin
            if (step && !wake_go) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step && (scan_idx_ff == mbq_pkg::ENT_W'(ME - 1))) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (step) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         wake_cnt_ff   <= '0;
         scan_idx_ff   <= '0;
         mem_lat_ff    <= mbq_pkg::MEM_LAT_RESET;
         l2_lat_ff     <= mbq_pkg::L2_LAT_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            if (csr_index == mbq_pkg::CSR_MEM_LAT) begin
               mem_lat_ff <= csr_data;
            end else begin
               l2_lat_ff <= csr_data[mbq_pkg::L2LAT_W-1:0];
            end
         end
         if (out_free) begin
            rsp_valid_ff <= push;
         end
         if (step) begin
            if (new_valid) begin
               hold_valid_ff <= 1'b1;
            end else if (state_ff == ST_DONE) begin
               hold_valid_ff <= 1'b0;
            end
         end
         if (in_exec) begin
            wake_cnt_ff <= '0;
            scan_idx_ff <= '0;
         end
         if (step && (state_ff == ST_WAKE) && wake_go) begin
            wake_cnt_ff <= wake_cnt_ff + mbq_pkg::WAKE_W'(1);
         end
         if (step && (state_ff == ST_SCAN) && (scan_idx_ff != mbq_pkg::ENT_W'(ME - 1))) begin
            scan_idx_ff <= scan_idx_ff + mbq_pkg::ENT_W'(1);
         end
      end
   end

   // payload staging
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         addr_ff  <= req_address;
         hit_ff   <= req_hit_in_l2;
         ic_ff    <= req_is_icache;
         rob_ff   <= req_rob_tag;
         thr_ff   <= req_thread_id;
         lslot_ff <= req_load_slot;
      end
      if (step && new_valid) begin
         hold_ff <= new_res;
      end
      if (push) begin
         rsp_ff      <= hold_ff;
         rsp_last_ff <= (state_ff == ST_DONE);
      end
   end

   // load slot state and links
   always_ff @(posedge clock) begin
      if (reset) begin
         linked_ff <= '0;
         for (int s = 0; s < LS; s++) begin
            slot_state_ff[s] <= mbq_pkg::SLOT_FREE;
         end
      end else if (step) begin
         for (int s = 0; s < LS; s++) begin
            case (state_ff)
               ST_EXEC: begin
                  case (cmd_ff)
                     mbq_pkg::CMD_LOAD_MISS: begin
                        if (load_ok && (free_idx == mbq_pkg::SLOT_W'(s))) begin
                           slot_state_ff[s] <= mbq_pkg::SLOT_WAIT;
                           linked_ff[s]     <= 1'b1;
                        end
                     end
                     mbq_pkg::CMD_ANNUL: begin
                        if (int'(lslot_ff) == s) begin
                           slot_state_ff[s] <= mbq_pkg::SLOT_FREE;
                           linked_ff[s]     <= 1'b0;
                        end
                     end
                     mbq_pkg::CMD_FLUSH: begin
                        if (gone_vec[s]) begin
                           slot_state_ff[s] <= mbq_pkg::SLOT_FREE;
                           linked_ff[s]     <= 1'b0;
                        end
                     end
                     mbq_pkg::CMD_RESTART: begin
                        slot_state_ff[s] <= mbq_pkg::SLOT_FREE;
                        linked_ff[s]     <= 1'b0;
                     end
                     default: begin
                        linked_ff[s] <= linked_ff[s];
                     end
                  endcase
               end
               ST_WAKE: begin
                  if (wake_go && (ready_idx == mbq_pkg::SLOT_W'(s))) begin
                     slot_state_ff[s] <= mbq_pkg::SLOT_FREE;
                  end
               end
               ST_SCAN: begin
                  // line reached L1: its waiters leave the entry, and become ready if it fills the data cache
                  if (l1_vec[s]) begin
                     linked_ff[s] <= 1'b0;
                     if (lines_sts.dcache && (slot_state_ff[s] == mbq_pkg::SLOT_WAIT)) begin
                        slot_state_ff[s] <= mbq_pkg::SLOT_READY;
                     end
                  end
               end
               default: begin
                  linked_ff[s] <= linked_ff[s];
               end
            endcase
         end
      end
   end

   // load slot payload
   always_ff @(posedge clock) begin
      if (in_exec && (cmd_ff == mbq_pkg::CMD_LOAD_MISS) && load_ok) begin
         slot_addr_ff[free_idx]  <= addr_ff;
         slot_rob_ff[free_idx]   <= rob_ff;
         slot_thr_ff[free_idx]   <= thr_ff;
         slot_entry_ff[free_idx] <= lines_sts.alloc_idx;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_ok          = rsp_ff.ok;
   assign rsp_slot        = rsp_ff.slot;
   assign rsp_out_address = rsp_ff.address;
   assign rsp_out_rob_tag = rsp_ff.rob_tag;
   assign rsp_out_thread  = rsp_ff.thread;
   assign rsp_fill_data   = rsp_ff.fill_data;
   assign rsp_fill_instr  = rsp_ff.fill_instr;
   assign rsp_last        = rsp_last_ff;

   `MBQ_ALWAYS(a_linked_busy, (linked_ff & ~busy_vec) == '0, "free load slot still linked")
   `MBQ_ALWAYS(a_wake_bound, wake_cnt_ff <= mbq_pkg::WAKE_W'(mbq_pkg::WAKEUPS_PER_TICK), "too many wakeups")
   `MBQ_IMPLIES(a_accept_clean, accept, !hold_valid_ff, "command accepted with a beat held")

endmodule
